>>> rtl/mcdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcdf_pkg;

  // Maze size
  localparam int MAZE_HEIGHT = 63;
  localparam int MAZE_WIDTH  = 63;

  // Field widths
  localparam int COORD_W = 6;
  localparam int DEPTH_W = 10;
  localparam int PERM_W  = 5;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_CARVE = 3'd1,
    KIND_BACK  = 3'd2,
    KIND_GOAL  = 3'd3,
    KIND_IDLE  = 3'd4
  } kind_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              cmd;
    logic [PERM_W-1:0] perm;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    coord_t             wall_row;
    coord_t             wall_col;
    coord_t             cell_row;
    coord_t             cell_col;
    logic [DEPTH_W-1:0] stack_depth;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START,
    ST_TOP,
    ST_PROBE,
    ST_CARVE,
    ST_WALL,
    ST_POP,
    ST_IDLE_RSP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_write;
    logic start_fin;
    logic top_rd;
    logic probe;
    logic carve_cell;
    logic carve_wall;
    logic pop;
    logic emit_idle;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idle_cond;
    logic clr_last;
    logic probe_hit;
    logic probe_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/mcdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mcdf_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  input  wire                  req_cmd,
  input  mcdf_pkg::dp_status_t sts,
  output mcdf_pkg::ctrl_cmd_t  ctl
);
  import mcdf_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load = 1'b1;
          if (req_cmd == CMD_START) begin
            state_next = ST_CLEAR;
          end else if (sts.idle_cond) begin
            state_next = ST_IDLE_RSP;
          end else begin
            state_next = ST_TOP;
          end
        end
      end
      ST_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (sts.out_free) begin
          ctl.start_fin = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_TOP: begin
        ctl.top_rd = 1'b1;
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        // evaluate previous probe while issuing the next one
        if (sts.probe_hit) begin
          state_next = ST_CARVE;
        end else if (sts.probe_end) begin
          state_next = ST_POP;
        end else begin
          ctl.probe = 1'b1;
        end
      end
      ST_CARVE: begin
        ctl.carve_cell = 1'b1;
        state_next     = ST_WALL;
      end
      ST_WALL: begin
        if (sts.out_free) begin
          ctl.carve_wall = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_POP: begin
        if (sts.out_free) begin
          ctl.pop    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE_RSP: begin
        if (sts.out_free) begin
          ctl.emit_idle = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mcdf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mcdf_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  mcdf_pkg::req_t       req,
  input  mcdf_pkg::ctrl_cmd_t  ctl,
  output mcdf_pkg::dp_status_t sts,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output mcdf_pkg::rsp_t       rsp
);
  import mcdf_pkg::*;

  localparam int STACK_CAP  = (MAZE_HEIGHT / 2) * (MAZE_WIDTH / 2);
  localparam int STK_AW     = $clog2(STACK_CAP);
  localparam int GRID_AW    = 2 * COORD_W;
  localparam int GRID_DEPTH = 1 << GRID_AW;
  localparam int PROBE_N    = 4;

  localparam logic [COORD_W:0] ROW_LIM = (COORD_W + 1)'(MAZE_HEIGHT);
  localparam logic [COORD_W:0] COL_LIM = (COORD_W + 1)'(MAZE_WIDTH);
  localparam logic [COORD_W:0] STEP2   = (COORD_W + 1)'(2);
  localparam logic [COORD_W:0] STEP1   = (COORD_W + 1)'(1);
  localparam coord_t START_RC = COORD_W'(1);
  localparam coord_t GOAL_ROW = COORD_W'(MAZE_HEIGHT - 2);
  localparam coord_t GOAL_COL = COORD_W'(MAZE_WIDTH - 2);
  localparam logic [DEPTH_W-1:0] CAP_D = DEPTH_W'(STACK_CAP);
  localparam logic [DEPTH_W-1:0] ONE_D = DEPTH_W'(1);

  // Direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // entry [0] is tried first
  typedef logic [3:0][1:0] dir_order_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } stk_entry_t;

  typedef struct packed {
    logic   inb;
    coord_t nr;
    coord_t nc;
    coord_t wr;
    coord_t wc;
  } nbr_t;

  // Lexicographic try order, index taken modulo 24
  function automatic dir_order_t perm_order(logic [PERM_W-1:0] p);
    logic [PERM_W-1:0] pm;
    dir_order_t        ord;
    pm = (p >= PERM_W'(24)) ? (p - PERM_W'(24)) : p;
    case (pm)
      5'd0:    ord = {DIR_RIGHT, DIR_LEFT,  DIR_DOWN,  DIR_UP};
      5'd1:    ord = {DIR_LEFT,  DIR_RIGHT, DIR_DOWN,  DIR_UP};
      5'd2:    ord = {DIR_RIGHT, DIR_DOWN,  DIR_LEFT,  DIR_UP};
      5'd3:    ord = {DIR_DOWN,  DIR_RIGHT, DIR_LEFT,  DIR_UP};
      5'd4:    ord = {DIR_LEFT,  DIR_DOWN,  DIR_RIGHT, DIR_UP};
      5'd5:    ord = {DIR_DOWN,  DIR_LEFT,  DIR_RIGHT, DIR_UP};
      5'd6:    ord = {DIR_RIGHT, DIR_LEFT,  DIR_UP,    DIR_DOWN};
      5'd7:    ord = {DIR_LEFT,  DIR_RIGHT, DIR_UP,    DIR_DOWN};
      5'd8:    ord = {DIR_RIGHT, DIR_UP,    DIR_LEFT,  DIR_DOWN};
      5'd9:    ord = {DIR_UP,    DIR_RIGHT, DIR_LEFT,  DIR_DOWN};
      5'd10:   ord = {DIR_LEFT,  DIR_UP,    DIR_RIGHT, DIR_DOWN};
      5'd11:   ord = {DIR_UP,    DIR_LEFT,  DIR_RIGHT, DIR_DOWN};
      5'd12:   ord = {DIR_RIGHT, DIR_DOWN,  DIR_UP,    DIR_LEFT};
      5'd13:   ord = {DIR_DOWN,  DIR_RIGHT, DIR_UP,    DIR_LEFT};
      5'd14:   ord = {DIR_RIGHT, DIR_UP,    DIR_DOWN,  DIR_LEFT};
      5'd15:   ord = {DIR_UP,    DIR_RIGHT, DIR_DOWN,  DIR_LEFT};
      5'd16:   ord = {DIR_DOWN,  DIR_UP,    DIR_RIGHT, DIR_LEFT};
      5'd17:   ord = {DIR_UP,    DIR_DOWN,  DIR_RIGHT, DIR_LEFT};
      5'd18:   ord = {DIR_LEFT,  DIR_DOWN,  DIR_UP,    DIR_RIGHT};
      5'd19:   ord = {DIR_DOWN,  DIR_LEFT,  DIR_UP,    DIR_RIGHT};
      5'd20:   ord = {DIR_LEFT,  DIR_UP,    DIR_DOWN,  DIR_RIGHT};
      5'd21:   ord = {DIR_UP,    DIR_LEFT,  DIR_DOWN,  DIR_RIGHT};
      5'd22:   ord = {DIR_DOWN,  DIR_UP,    DIR_LEFT,  DIR_RIGHT};
      default: ord = {DIR_UP,    DIR_DOWN,  DIR_LEFT,  DIR_RIGHT};
    endcase
    return ord;
  endfunction

  // Cell two away, the wall between, and the border check
  function automatic nbr_t neighbor(coord_t r, coord_t c, logic [1:0] d);
    logic [COORD_W:0] r7, c7, nr7, nc7, wr7, wc7;
    nbr_t             n;
    r7  = {1'b0, r};
    c7  = {1'b0, c};
    nr7 = r7;
    nc7 = c7;
    wr7 = r7;
    wc7 = c7;
    unique case (d)
      DIR_UP: begin
        nr7 = r7 - STEP2;
        wr7 = r7 - STEP1;
      end
      DIR_DOWN: begin
        nr7 = r7 + STEP2;
        wr7 = r7 + STEP1;
      end
      DIR_LEFT: begin
        nc7 = c7 - STEP2;
        wc7 = c7 - STEP1;
      end
      default: begin
        nc7 = c7 + STEP2;
        wc7 = c7 + STEP1;
      end
    endcase
    // underflow wraps above the limit, so one compare covers both sides
    n.inb = (nr7 != '0) && (nr7 < ROW_LIM) && (nc7 != '0) && (nc7 < COL_LIM);
    n.nr  = nr7[COORD_W-1:0];
    n.nc  = nc7[COORD_W-1:0];
    n.wr  = wr7[COORD_W-1:0];
    n.wc  = wc7[COORD_W-1:0];
    return n;
  endfunction

  // Grid memory, one bit per cell, 1 = open
  logic                 grid_mem [GRID_DEPTH];
  logic                 grid_we;
  logic [GRID_AW-1:0]   grid_wa;
  logic                 grid_wd;
  logic                 grid_re;
  logic [GRID_AW-1:0]   grid_ra;
  logic                 grid_rdata;

  // Path stack memory
  stk_entry_t           stk_mem [STACK_CAP];
  logic                 stk_we;
  logic [STK_AW-1:0]    stk_wa;
  stk_entry_t           stk_wd;
  logic [STK_AW-1:0]    stk_ra;
  stk_entry_t           stk_rdata;

  // Control state
  logic [DEPTH_W-1:0]   stack_count;
  logic [DEPTH_W-1:0]   stack_count_next;
  logic [DEPTH_W-1:0]   count_m1;
  logic                 running;
  logic [GRID_AW-1:0]   clr_cnt;
  logic [2:0]           probe_k;
  logic                 p_valid;

  // Payload state
  dir_order_t           order;
  logic [1:0]           p_dir;
  nbr_t                 nb_probe;
  nbr_t                 sel;
  logic                 push_ok;
  logic                 last_pop;
  logic                 emit;
  rsp_t                 rsp_next;

  assign count_m1 = stack_count - ONE_D;
  assign push_ok  = stack_count < CAP_D;
  assign last_pop = (stack_count == ONE_D);
  assign nb_probe = neighbor(stk_rdata.row, stk_rdata.col, order[probe_k[1:0]]);
  assign sel      = neighbor(stk_rdata.row, stk_rdata.col, p_dir);
  assign emit     = ctl.start_fin | ctl.carve_wall | ctl.pop | ctl.emit_idle;

  // Status
  assign sts.idle_cond = !running || (stack_count == '0);
  assign sts.clr_last  = &clr_cnt;
  assign sts.probe_hit = p_valid & ~grid_rdata;
  assign sts.probe_end = (probe_k == 3'(PROBE_N));
  assign sts.out_free  = !rsp_valid || rsp_ready;

  // Grid port selection
  always_comb begin
    grid_we = 1'b0;
    grid_wa = clr_cnt;
    grid_wd = 1'b1;
    if (ctl.clr_write) begin
      grid_we = 1'b1;
      grid_wd = 1'b0;
    end else if (ctl.start_fin) begin
      grid_we = 1'b1;
      grid_wa = {START_RC, START_RC};
    end else if (ctl.carve_cell) begin
      grid_we = 1'b1;
      grid_wa = {sel.nr, sel.nc};
    end else if (ctl.carve_wall) begin
      grid_we = 1'b1;
      grid_wa = {sel.wr, sel.wc};
    end else if (ctl.pop && last_pop) begin
      grid_we = 1'b1;
      grid_wa = {GOAL_ROW, GOAL_COL};
    end
  end

  assign grid_re = ctl.probe;
  assign grid_ra = {nb_probe.nr, nb_probe.nc};

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    if (grid_re) begin
      grid_rdata <= grid_mem[grid_ra];
    end
  end

  // Stack port selection
  assign stk_we = ctl.start_fin | (ctl.carve_cell & push_ok);
  assign stk_wa = ctl.start_fin ? '0 : stack_count[STK_AW-1:0];
  assign stk_wd = ctl.start_fin ? stk_entry_t'{row: START_RC, col: START_RC}
                                : stk_entry_t'{row: sel.nr, col: sel.nc};
  assign stk_ra = count_m1[STK_AW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (ctl.top_rd) begin
      stk_rdata <= stk_mem[stk_ra];
    end
  end

  // Stack depth
  always_comb begin
    stack_count_next = stack_count;
    if (ctl.start_fin) begin
      stack_count_next = ONE_D;
    end else if (ctl.carve_cell && push_ok) begin
      stack_count_next = stack_count + ONE_D;
    end else if (ctl.pop) begin
      stack_count_next = count_m1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      running     <= 1'b0;
      clr_cnt     <= '0;
      probe_k     <= '0;
      p_valid     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      stack_count <= stack_count_next;
      if (ctl.start_fin) begin
        running <= 1'b1;
      end else if (ctl.pop && last_pop) begin
        running <= 1'b0;
      end
      if (ctl.load) begin
        clr_cnt <= '0;
      end else if (ctl.clr_write) begin
        clr_cnt <= clr_cnt + GRID_AW'(1);
      end
      if (ctl.top_rd) begin
        probe_k <= '0;
      end else if (ctl.probe) begin
        probe_k <= probe_k + 3'd1;
      end
      // hit flag only covers the probe issued in the previous cycle
      p_valid <= ctl.probe & nb_probe.inb;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      order <= perm_order(req.perm);
    end
    if (ctl.probe) begin
      p_dir <= order[probe_k[1:0]];
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  // Result item
  always_comb begin
    rsp_next             = '0;
    rsp_next.kind        = KIND_IDLE;
    rsp_next.stack_depth = stack_count;
    if (ctl.start_fin) begin
      rsp_next.kind        = KIND_START;
      rsp_next.cell_row    = START_RC;
      rsp_next.cell_col    = START_RC;
      rsp_next.stack_depth = ONE_D;
    end else if (ctl.carve_wall) begin
      rsp_next.kind     = KIND_CARVE;
      rsp_next.wall_row = sel.wr;
      rsp_next.wall_col = sel.wc;
      rsp_next.cell_row = sel.nr;
      rsp_next.cell_col = sel.nc;
    end else if (ctl.pop) begin
      if (last_pop) begin
        rsp_next.kind        = KIND_GOAL;
        rsp_next.cell_row    = GOAL_ROW;
        rsp_next.cell_col    = GOAL_COL;
        rsp_next.stack_depth = '0;
      end else begin
        rsp_next.kind        = KIND_BACK;
        rsp_next.stack_depth = count_m1;
      end
    end
  end

`ifndef SYNTHESIS
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten while pending");

  // depth never passes the stack capacity
  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CAP_D)
    else $error("stack depth above capacity");

  // an active search always has a cell on the stack
  a_running_depth: assert property (@(posedge clk) disable iff (rst)
    running |-> (stack_count != '0))
    else $error("running with empty stack");

  // a probe hit only follows a probe
  a_hit_after_probe: assert property (@(posedge clk) disable iff (rst)
    sts.probe_hit |-> $past(ctl.probe))
    else $error("probe hit without a probe");
`endif

endmodule

`default_nettype wire

>>> rtl/maze_carve_depth_first.sv
// Step item: reads the stack top, then does one grid read per tried direction
// (up to four, overlapped with evaluation).
// Idle step: answered without a grid or stack read. Start item: runs a
// one-cell-per-cycle clearing pass over the 4096-entry grid memory.
// One item at a time, next one taken the cycle after its result is produced.
// Synchronous active-high reset clears the stack depth and the running flag.
`timescale 1ns / 1ps
`default_nettype none

module maze_carve_depth_first (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_ready,
  input  mcdf_pkg::req_t  req,
  output logic            rsp_valid,
  input  wire             rsp_ready,
  output mcdf_pkg::rsp_t  rsp
);
  import mcdf_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // Sequencer
  mcdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_cmd   (req.cmd),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Grid, stack and result register
  mcdf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
